// ===== design/srtf_pkg.sv =====
// ============================================================================
// srtf_pkg
// Shared types and constants for the SRTF scheduler.
// ============================================================================
package srtf_pkg;

    localparam int TimeW  = 24;
    localparam int FieldW = 16;
    localparam int DigitW = 4;
    localparam int NumDig = TimeW / DigitW;
    localparam int DigCntW = 3;
    localparam logic [TimeW-1:0] TickMax = {TimeW{1'b1}};

    localparam int InDataW  = 32;
    localparam int OutDataW = 112;

    typedef logic [2:0] status_t;
    localparam status_t StLoaded   = 3'd0;
    localparam status_t StRejected = 3'd1;
    localparam status_t StIdleTick = 3'd2;
    localparam status_t StRan      = 3'd3;
    localparam status_t StFinished = 3'd4;

    localparam logic KindLoad = 1'b0;
    localparam logic KindTick = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SUB,
        S_RESULT
    } state_t;

endpackage

// ===== design/srtf_preemptive_scheduler_top.sv =====
// ============================================================================
// srtf_preemptive_scheduler_top
// Preemptive shortest-remaining-time-first scheduler with a job table.
// ============================================================================
// Usage:
//   Input stream (s_*): s_tuser is the item kind (0 load job, 1 tick);
//   s_tdata carries arrival_time and burst_time. A load appends the job to
//   the next free slot, or is rejected when the table is full or the burst
//   is zero. A tick picks the arrived job with the least nonzero remaining
//   time (lowest slot on a tie), runs it one tick and advances time.
//   Output stream (m_*): one result transaction per input transaction.
//   Steps per item (accept to result ready); no new item is taken until
//   the result has moved to the output register:
//     load: straight to the result stage
//     tick: scan of the N jobs loaded, one table slot read per cycle through
//           the single read port of the job table; a tick that finishes a job
//           adds the nibble-serial subtract for turnaround and waiting times
//   A result waits in the output register while the receiver stalls; the
//   next input transaction is still taken, and the block holds its second
//   result in its result stage until the output register frees up.
//   Reset clears job count, finished count and time; the table contents
//   are undefined until loaded and only loaded slots are ever scanned.
// ============================================================================
module srtf_preemptive_scheduler_top
    import srtf_pkg::*;
#(
    parameter int MAX_JOBS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [15:0] arrival_time, [31:16] burst_time
    input  logic [InDataW-1:0]  s_tdata,
    // [0] kind
    input  logic                s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [2:0] status, [7:3] job_id, [31:8] time_now, [55:32] completion_time,
    // [79:56] waiting_time, [103:80] turnaround_time, [104] all_done,
    // [111:105] zero
    output logic [OutDataW-1:0] m_tdata
);

    localparam int IdxW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CntW  = $clog2(MAX_JOBS + 1);
    localparam int WordW = 3 * FieldW;

    // Job table: {arrival, burst, remaining}
    logic [WordW-1:0] mem [MAX_JOBS];
    logic [WordW-1:0] mem_q;
    logic [IdxW-1:0]  rd_addr;
    logic             mem_we;
    logic [IdxW-1:0]  wr_addr;
    logic [WordW-1:0] wr_data;

    state_t state_reg, state_next;

    logic [CntW-1:0]   loaded_reg;
    logic [CntW-1:0]   finished_reg;
    logic [TimeW-1:0]  tick_reg;
    logic [IdxW-1:0]   scan_reg;
    logic              found_reg;
    logic [IdxW-1:0]   best_idx_reg;
    logic [FieldW-1:0] best_rem_reg;
    logic [FieldW-1:0] best_arr_reg;
    logic [FieldW-1:0] best_bur_reg;

    // Result stage
    status_t           res_status_reg;
    logic [4:0]        res_id_reg;
    logic [TimeW-1:0]  res_now_reg;
    logic [TimeW-1:0]  res_comp_reg;

    // Nibble-serial subtractor shift registers
    logic [TimeW-1:0]   comp_sh_reg;
    logic [TimeW-1:0]   arr_sh_reg;
    logic [TimeW-1:0]   bur_sh_reg;
    logic [TimeW-1:0]   tat_sh_reg;
    logic [TimeW-1:0]   wait_sh_reg;
    logic               brw_tat_reg;
    logic               brw_wait_reg;
    logic [DigCntW-1:0] dig_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [OutDataW-1:0] m_tdata_reg;

    // Fields of the incoming transaction
    logic              in_kind;
    logic [FieldW-1:0] in_arr;
    logic [FieldW-1:0] in_bur;
    logic              accept;
    logic              table_full;
    logic              scan_last;
    logic              out_free;

    // Current scanned entry
    logic [FieldW-1:0] ent_arr;
    logic [FieldW-1:0] ent_bur;
    logic [FieldW-1:0] ent_rem;
    logic              ent_pick;

    // One digit of each subtraction
    logic [DigitW:0]   tat_dig;
    logic [DigitW:0]   wait_dig;

    assign in_kind    = s_tuser;
    assign in_arr     = s_tdata[FieldW-1:0];
    assign in_bur     = s_tdata[2*FieldW-1:FieldW];
    assign accept     = s_tvalid && s_tready;
    assign table_full = (loaded_reg == CntW'(MAX_JOBS));
    assign scan_last  = ({1'b0, scan_reg} == (loaded_reg - CntW'(1)));
    assign out_free   = !m_tvalid_reg || m_tready;

    assign ent_arr  = mem_q[3*FieldW-1:2*FieldW];
    assign ent_bur  = mem_q[2*FieldW-1:FieldW];
    assign ent_rem  = mem_q[FieldW-1:0];
    assign ent_pick = ({{(TimeW-FieldW){1'b0}}, ent_arr} <= tick_reg) &&
                      (ent_rem != '0) && (!found_reg || (ent_rem < best_rem_reg));

    assign tat_dig  = {1'b0, comp_sh_reg[DigitW-1:0]} - {1'b0, arr_sh_reg[DigitW-1:0]}
                      - {{DigitW{1'b0}}, brw_tat_reg};
    assign wait_dig = {1'b0, tat_dig[DigitW-1:0]} - {1'b0, bur_sh_reg[DigitW-1:0]}
                      - {{DigitW{1'b0}}, brw_wait_reg};

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_kind == KindLoad)
                        state_next = S_RESULT;
                    else if (loaded_reg == '0)
                        state_next = S_DECIDE;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (found_reg && (best_rem_reg == FieldW'(1)))
                    state_next = S_SUB;
                else
                    state_next = S_RESULT;
            end
            S_SUB:
            begin
                if (dig_reg == DigCntW'(NumDig - 1))
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready = 1'b0;
        mem_we   = 1'b0;
        wr_addr  = loaded_reg[IdxW-1:0];
        wr_data  = {in_arr, in_bur, in_bur};
        rd_addr  = scan_reg + IdxW'(1);
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                rd_addr  = '0;
                mem_we   = s_tvalid && (in_kind == KindLoad) && !table_full &&
                           (in_bur != '0);
            end
            S_DECIDE:
            begin
                mem_we  = found_reg;
                wr_addr = best_idx_reg;
                wr_data = {best_arr_reg, best_bur_reg, best_rem_reg - FieldW'(1)};
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Job table
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        mem_q <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            loaded_reg   <= '0;
            finished_reg <= '0;
            tick_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_we && (state_reg == S_IDLE))
                loaded_reg <= loaded_reg + CntW'(1);
            if ((state_reg == S_DECIDE) && found_reg && (best_rem_reg == FieldW'(1)))
                finished_reg <= finished_reg + CntW'(1);
            if ((state_reg == S_DECIDE) && (tick_reg != TickMax))
                tick_reg <= tick_reg + TimeW'(1);
            if ((state_reg == S_RESULT) && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                scan_reg     <= '0;
                found_reg    <= 1'b0;
                res_now_reg  <= tick_reg;
                res_comp_reg <= '0;
                tat_sh_reg   <= '0;
                wait_sh_reg  <= '0;
                if (mem_we)
                begin
                    res_status_reg <= StLoaded;
                    res_id_reg     <= 5'(loaded_reg + CntW'(1));
                end
                else
                begin
                    res_status_reg <= StRejected;
                    res_id_reg     <= '0;
                end
            end
            S_SCAN:
            begin
                scan_reg <= scan_reg + IdxW'(1);
                if (ent_pick)
                begin
                    found_reg    <= 1'b1;
                    best_idx_reg <= scan_reg;
                    best_rem_reg <= ent_rem;
                    best_arr_reg <= ent_arr;
                    best_bur_reg <= ent_bur;
                end
            end
            S_DECIDE:
            begin
                dig_reg      <= '0;
                brw_tat_reg  <= 1'b0;
                brw_wait_reg <= 1'b0;
                comp_sh_reg  <= (tick_reg != TickMax) ? tick_reg + TimeW'(1) : TickMax;
                arr_sh_reg   <= {{(TimeW-FieldW){1'b0}}, best_arr_reg};
                bur_sh_reg   <= {{(TimeW-FieldW){1'b0}}, best_bur_reg};
                if (!found_reg)
                begin
                    res_status_reg <= StIdleTick;
                    res_id_reg     <= '0;
                    res_comp_reg   <= '0;
                end
                else
                begin
                    res_id_reg <= 5'({1'b0, best_idx_reg} + (IdxW+1)'(1));
                    if (best_rem_reg == FieldW'(1))
                    begin
                        res_status_reg <= StFinished;
                        res_comp_reg   <= (tick_reg != TickMax) ?
                                          tick_reg + TimeW'(1) : TickMax;
                    end
                    else
                    begin
                        res_status_reg <= StRan;
                        res_comp_reg   <= '0;
                    end
                end
            end
            S_SUB:
            begin
                // low digit first; results shift in from the top
                dig_reg      <= dig_reg + DigCntW'(1);
                comp_sh_reg  <= comp_sh_reg >> DigitW;
                arr_sh_reg   <= arr_sh_reg >> DigitW;
                bur_sh_reg   <= bur_sh_reg >> DigitW;
                tat_sh_reg   <= {tat_dig[DigitW-1:0], tat_sh_reg[TimeW-1:DigitW]};
                wait_sh_reg  <= {wait_dig[DigitW-1:0], wait_sh_reg[TimeW-1:DigitW]};
                brw_tat_reg  <= tat_dig[DigitW];
                brw_wait_reg <= wait_dig[DigitW];
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {7'd0,
                                    (loaded_reg != '0) && (finished_reg == loaded_reg),
                                    brw_tat_reg ? {TimeW{1'b0}} : tat_sh_reg,
                                    (brw_tat_reg || brw_wait_reg) ? {TimeW{1'b0}} :
                                                                    wait_sh_reg,
                                    res_comp_reg,
                                    res_now_reg,
                                    res_id_reg,
                                    res_status_reg};
                end
            end
            default:
            begin
                scan_reg <= scan_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sim/srtf_preemptive_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srtf_preemptive_scheduler_top_tb
// Self-checking bench for the SRTF scheduler: a behavioral job table
// predicts one result per input transaction, and every output transaction
// is compared field by field against the oldest prediction. Both stream
// sides see random gaps, one long output hold-off and two full drains.
// ============================================================================
module srtf_preemptive_scheduler_top_tb;
    import srtf_pkg::*;

    localparam int JobSlots = 16;

    // Fields of one result transaction, laid out as m_tdata[104:0].
    typedef struct packed {
        logic             all_done;
        logic [TimeW-1:0] turnaround_time;
        logic [TimeW-1:0] waiting_time;
        logic [TimeW-1:0] completion_time;
        logic [TimeW-1:0] time_now;
        logic [4:0]       job_id;
        status_t          status;
    } sched_result_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;   // [15:0] arrival_time, [31:16] burst_time
    logic                s_tuser;   // [0] kind
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;   // status, job_id, times, all_done, pad

    // Predicted scheduler state.
    logic [FieldW-1:0] job_arrival [JobSlots];
    logic [FieldW-1:0] job_burst   [JobSlots];
    logic [FieldW-1:0] job_left    [JobSlots];
    int                jobs_loaded;
    int                jobs_finished;
    logic [TimeW-1:0]  sched_clock;

    sched_result_t expected_results [$];
    int            error_count;
    int            mismatch_count;

    // Traffic shaping: gaps_on for sender and receiver, hold_request for the receiver.
    bit gaps_on;
    int hold_request;

    srtf_preemptive_scheduler_top #(
        .MAX_JOBS (JobSlots)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous fixed limit; a correct run needs a small fraction of it.
    initial
    begin
        #20_000_000;
        $display("srtf_preemptive_scheduler_top_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: applies one transaction to the job table and returns the
    // result it causes. Tick saturation needs 2^24 ticks, far beyond this
    // run, but is modeled anyway.
    // ------------------------------------------------------------------------
    function automatic sched_result_t schedule_step(logic kind, logic [FieldW-1:0] arr,
                                                    logic [FieldW-1:0] bur);
        sched_result_t r;
        int            best;
        int unsigned   best_left;
        int unsigned   done_at;
        int unsigned   span;
        r = '0;
        r.time_now = sched_clock;
        best = -1;
        best_left = 0;
        if (kind == KindLoad)
        begin
            if (jobs_loaded >= JobSlots || bur == '0)
                r.status = StRejected;
            else
            begin
                job_arrival[jobs_loaded] = arr;
                job_burst[jobs_loaded]   = bur;
                job_left[jobs_loaded]    = bur;
                jobs_loaded++;
                r.status = StLoaded;
                r.job_id = 5'(jobs_loaded);
            end
        end
        else
        begin
            // least remaining time among arrived jobs; strict < keeps lowest slot
            for (int i = 0; i < jobs_loaded; i++)
            begin
                if (TimeW'(job_arrival[i]) <= sched_clock && job_left[i] != '0 &&
                    (best < 0 || job_left[i] < best_left))
                begin
                    best = i;
                    best_left = job_left[i];
                end
            end
            if (best < 0)
                r.status = StIdleTick;
            else
            begin
                job_left[best] = job_left[best] - 1'b1;
                r.job_id = 5'(best + 1);
                if (best_left == 1)
                begin
                    r.status = StFinished;
                    jobs_finished++;
                    done_at = (sched_clock < TickMax) ? sched_clock + 1 : TickMax;
                    span = (done_at > job_arrival[best]) ? done_at - job_arrival[best] : 0;
                    r.completion_time = TimeW'(done_at);
                    r.turnaround_time = TimeW'(span);
                    r.waiting_time    = (span > job_burst[best]) ?
                                        TimeW'(span - job_burst[best]) : '0;
                end
                else
                    r.status = StRan;
            end
            if (sched_clock != TickMax)
                sched_clock++;
        end
        r.all_done = (jobs_loaded > 0 && jobs_finished == jobs_loaded);
        return r;
    endfunction

    // Mostly short gaps, some long ones; none while gaps are switched off.
    function automatic int pick_gap();
        int roll;
        if (!gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One input transaction: offer, wait for acceptance, predict, then an optional random idle gap.
    task automatic send_item(logic kind, logic [FieldW-1:0] arr, logic [FieldW-1:0] bur);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {bur, arr};
        do
            @(posedge clk);
        while (!s_tready);
        expected_results.push_back(schedule_step(kind, arr, bur));
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random ready with occasional long stalls, plus a counted
    // hold-off on request.
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (!gaps_on || $urandom_range(0, 3) != 0)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                        $urandom_range(1, 3)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        sched_result_t got;
        sched_result_t want;
        bit            bad;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[104:0];
            if (expected_results.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected: status %0d job %0d",
                             $realtime, got.status, got.job_id);
            end
            else
            begin
                want = expected_results.pop_front();
                bad = (got.status != want.status) || (got.job_id != want.job_id) ||
                      (got.time_now != want.time_now) ||
                      (got.completion_time != want.completion_time) ||
                      (got.waiting_time != want.waiting_time) ||
                      (got.turnaround_time != want.turnaround_time) ||
                      (got.all_done != want.all_done) || (m_tdata[111:105] != '0);
                if (bad)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("%0t: mismatch exp st=%0d id=%0d now=%0d ct=%0d wt=%0d tat=%0d ad=%0d",
                                 $realtime, want.status, want.job_id, want.time_now,
                                 want.completion_time, want.waiting_time,
                                 want.turnaround_time, want.all_done);
                        $display("%0t:          got st=%0d id=%0d now=%0d ct=%0d wt=%0d tat=%0d ad=%0d pad=%0h",
                                 $realtime, got.status, got.job_id, got.time_now,
                                 got.completion_time, got.waiting_time,
                                 got.turnaround_time, got.all_done, m_tdata[111:105]);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Idle tick on an empty table, zero-burst loads at both arrival extremes.
    task automatic run_empty_and_reject();
        send_item(KindTick, 16'd0, 16'd0);
        send_item(KindLoad, 16'd0, 16'd0);
        send_item(KindLoad, 16'hFFFF, 16'd0);
    endtask

    // Late arrival, equal remaining times (lowest slot wins), a short job
    // loaded behind a longer one, and all_done going high.
    task automatic run_tie_and_late_arrival();
        send_item(KindLoad, 16'd2, 16'd3);
        send_item(KindTick, 16'd0, 16'd0);
        send_item(KindLoad, 16'd0, 16'd2);
        send_item(KindLoad, 16'd0, 16'd2);
        repeat (3) send_item(KindTick, 16'd0, 16'd0);
        send_item(KindLoad, 16'd0, 16'd1);
        repeat (6) send_item(KindTick, 16'd0, 16'd0);
    endtask

    // New job after everything finished: all_done drops and comes back.
    task automatic run_reload_after_done();
        send_item(KindLoad, 16'd5, 16'd1);
        send_item(KindTick, 16'd0, 16'd0);
    endtask

    // Receiver holds off while the sender keeps offering: the block fills
    // its output and result stages and must stall its input.
    task automatic run_output_hold_off();
        bit saved;
        saved = gaps_on;
        gaps_on = 1'b0;
        hold_request = 300;
        repeat (12) send_item(KindTick, 16'd0, 16'd0);
        gaps_on = saved;
    endtask

    // Mixed traffic: sparse well-formed loads near the current time, mostly
    // ticks, some zero-burst loads and full-range loads once the table is full.
    task automatic run_random_mix(int count);
        int                roll;
        logic [FieldW-1:0] arr;
        logic [FieldW-1:0] bur;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (jobs_loaded < JobSlots && roll < 3)
            begin
                if ($urandom_range(0, 3) == 0)
                    arr = FieldW'($urandom_range(0, sched_clock));
                else
                    arr = FieldW'(sched_clock + $urandom_range(0, 24));
                bur = FieldW'($urandom_range(1, 40));
                send_item(KindLoad, arr, bur);
            end
            else if (roll < 6)
                send_item(KindLoad, FieldW'($urandom_range(0, 16'hFFFF)), 16'd0);
            else if (roll < 14 && jobs_loaded >= JobSlots)
                send_item(KindLoad, FieldW'($urandom_range(0, 16'hFFFF)),
                          FieldW'($urandom_range(0, 16'hFFFF)));
            else
                send_item(KindTick, FieldW'($urandom()), FieldW'($urandom()));
        end
        gaps_on = 1'b1;
    endtask

    // Sender stops until every outstanding result has arrived.
    task automatic run_pause_until_idle();
        drain_results();
        send_item(KindTick, 16'd0, 16'd0);
    endtask

    // Fill the table, then loads must bounce regardless of their fields;
    // finally run every job to completion.
    task automatic run_table_full();
        int guard;
        while (jobs_loaded < JobSlots)
            send_item(KindLoad, FieldW'(sched_clock), FieldW'($urandom_range(1, 3)));
        send_item(KindLoad, 16'hFFFF, 16'hFFFF);
        send_item(KindLoad, 16'd0, 16'd1);
        send_item(KindLoad, 16'hFFFF, 16'd0);
        repeat (4) send_item(KindLoad, FieldW'($urandom()), FieldW'($urandom()));
        guard = 0;
        while (jobs_finished != jobs_loaded && guard < 2000)
        begin
            send_item(KindTick, 16'd0, 16'd0);
            guard++;
        end
        send_item(KindTick, 16'd0, 16'd0);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KindLoad;
        jobs_loaded    = 0;
        jobs_finished  = 0;
        sched_clock    = '0;
        error_count    = 0;
        mismatch_count = 0;
        gaps_on        = 1'b1;
        hold_request   = 0;
        for (int i = 0; i < JobSlots; i++)
        begin
            job_arrival[i] = '0;
            job_burst[i]   = '0;
            job_left[i]    = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_empty_and_reject();
        run_tie_and_late_arrival();
        run_reload_after_done();
        run_output_hold_off();
        run_random_mix(450);
        run_pause_until_idle();
        run_random_mix(420);
        run_table_full();

        drain_results();
        // margin for the longest tick with a full table to finish
        repeat (40) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("srtf_preemptive_scheduler_top_tb passed");
        else
            $display("srtf_preemptive_scheduler_top_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/srtf_pkg.sv
design/srtf_preemptive_scheduler_top.sv
sim/srtf_preemptive_scheduler_top_tb.sv
